### rtl/sfb_pkg.sv
// Shared types, constants and lookup functions for the seven-segment frame builder.
// Used by every module of the block but the queue; no dependencies of its own.
package sfb_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FIRST_CMD  = 2'd0;
    localparam logic [1:0] CFG_ADDR_CMD   = 2'd1;
    localparam logic [1:0] CFG_BLANK_CODE = 2'd2;

    localparam logic [7:0] FIRST_CMD_RESET  = 8'd64;
    localparam logic [7:0] ADDR_CMD_RESET   = 8'd192;
    localparam logic [7:0] BLANK_CODE_RESET = 8'd0;

    // Digit codes 0..15 are hex glyphs, 16 a colon, 17 a dash, 18 anything blank.
    localparam int DIG_CODE_W = 5;
    typedef logic [DIG_CODE_W-1:0] dig_code_t;
    localparam dig_code_t DIG_BLANK = 5'd18;

    localparam logic [7:0] COLON_SEG    = 8'h01;
    localparam logic [7:0] VACANT_SEG   = 8'h00;
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int          DIV10_SHIFT = 19;

    typedef struct packed {
        logic [15:0] value;
        logic        radix_mode;
        logic [2:0]  shift_positions;
        logic [2:0]  brightness_level;
        logic        colon_on;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       stop_after;
        logic       last_of_frame;
    } out_item_t;

    typedef struct packed {
        logic [7:0] first_cmd;
        logic [7:0] addr_cmd;
        logic [7:0] blank_code;
    } cfg_t;

    // Per-frame options that travel with the digit codes through the queue.
    typedef struct packed {
        logic       colon_or;
        logic [2:0] shift;
        logic [2:0] bright;
    } entry_ctl_t;

    typedef enum logic [1:0] {
        PH_CMD,
        PH_ADDR,
        PH_DIGIT,
        PH_BRIGHT
    } phase_t;

    function automatic logic [7:0] seg_lookup(input dig_code_t code);
        logic [7:0] seg;
        case (code)
            5'd0:    seg = 8'hFC;
            5'd1:    seg = 8'h60;
            5'd2:    seg = 8'hDA;
            5'd3:    seg = 8'hF2;
            5'd4:    seg = 8'h66;
            5'd5:    seg = 8'hB6;
            5'd6:    seg = 8'hBE;
            5'd7:    seg = 8'hE0;
            5'd8:    seg = 8'hFE;
            5'd9:    seg = 8'hF6;
            5'd10:   seg = 8'hEE;
            5'd11:   seg = 8'h3E;
            5'd12:   seg = 8'h9C;
            5'd13:   seg = 8'h7A;
            5'd14:   seg = 8'h9E;
            5'd15:   seg = 8'h8E;
            5'd16:   seg = 8'h01;
            5'd17:   seg = 8'h02;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

    function automatic logic [7:0] bright_lookup(input logic [2:0] level);
        logic [7:0] code;
        case (level)
            3'd0:    code = 8'h01;
            3'd1:    code = 8'h91;
            3'd2:    code = 8'h51;
            3'd3:    code = 8'hD1;
            3'd4:    code = 8'h31;
            3'd5:    code = 8'hB1;
            3'd6:    code = 8'h71;
            default: code = 8'hF1;
        endcase
        return code;
    endfunction

endpackage

### rtl/sfb_front.sv
// Front end: accepts input transactions, splits the value into digit codes
// (one decimal digit per cycle) and applies leading-zero blanking. Uses sfb_pkg.
module sfb_front #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  sfb_pkg::in_item_t                       s_item,
    output logic                                    push_valid,
    input  logic                                    push_ready,
    output sfb_pkg::dig_code_t [DIGIT_COUNT-1:0]    push_digits,
    output sfb_pkg::entry_ctl_t                     push_ctl
);

    localparam int STEP_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIGIT_COUNT - 1);

    logic                  busy_reg,   busy_next;
    logic [STEP_W-1:0]     step_reg,   step_next;
    logic [15:0]           num_reg,    num_next;
    logic                  dec_reg,    dec_next;
    logic                  colon_reg,  colon_next;
    logic [2:0]            shift_reg,  shift_next;
    logic [2:0]            bright_reg, bright_next;
    sfb_pkg::dig_code_t    dig_reg [DIGIT_COUNT];

    logic                  done;
    logic                  accept;
    logic                  step_en;
    logic [31:0]           prod;
    logic [12:0]           quot;
    logic [15:0]           quot_x10;
    logic [15:0]           rem;
    sfb_pkg::dig_code_t    top_code;
    sfb_pkg::dig_code_t    hex_raw [DIGIT_COUNT];
    sfb_pkg::dig_code_t    raw     [DIGIT_COUNT];
    sfb_pkg::dig_code_t    coded   [DIGIT_COUNT];

    // Divide by ten with a reciprocal; exact for every 16-bit dividend.
    assign prod     = 32'(num_reg) * 32'(sfb_pkg::DIV10_MUL);
    assign quot     = prod[sfb_pkg::DIV10_SHIFT +: 13];
    assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
    assign rem      = num_reg - quot_x10;

    assign top_code = (num_reg >= 16'd18) ? sfb_pkg::DIG_BLANK
                                          : sfb_pkg::dig_code_t'(num_reg);

    genvar g;
    generate
        for (g = 0; g < DIGIT_COUNT; g++) begin : g_hex
            if (g < 4) begin : g_nib
                assign hex_raw[g] = {1'b0, num_reg[g*4 +: 4]};
            end else begin : g_zero
                assign hex_raw[g] = '0;
            end
        end
    endgenerate

    assign done       = !dec_reg || (step_reg == LAST_STEP);
    assign push_valid = busy_reg && done;
    assign s_ready    = !busy_reg || (done && push_ready);
    assign accept     = s_valid && s_ready;
    assign step_en    = busy_reg && !done;

    always_comb begin
        logic seen;
        logic blank;
        seen = 1'b0;
        for (int pos = DIGIT_COUNT - 1; pos >= 0; pos--) begin
            if (dec_reg) begin
                raw[pos] = (pos == DIGIT_COUNT - 1) ? top_code : dig_reg[pos];
            end else begin
                raw[pos] = hex_raw[pos];
            end
            blank = (raw[pos] == '0) && !seen && (pos != 0) && !(dec_reg && colon_reg);
            if (!blank) begin
                seen = 1'b1;
            end
            coded[pos] = blank ? sfb_pkg::DIG_BLANK : raw[pos];
        end
        // Queue entries hold digits in display order, most significant first.
        for (int p = 0; p < DIGIT_COUNT; p++) begin
            push_digits[p] = coded[DIGIT_COUNT - 1 - p];
        end
    end

    assign push_ctl.colon_or = dec_reg && colon_reg;
    assign push_ctl.shift    = shift_reg;
    assign push_ctl.bright   = bright_reg;

    always_comb begin
        busy_next   = busy_reg;
        step_next   = step_reg;
        num_next    = num_reg;
        dec_next    = dec_reg;
        colon_next  = colon_reg;
        shift_next  = shift_reg;
        bright_next = bright_reg;
        if (accept) begin
            busy_next   = 1'b1;
            step_next   = '0;
            num_next    = s_item.value;
            dec_next    = s_item.radix_mode;
            colon_next  = s_item.colon_on;
            shift_next  = s_item.shift_positions;
            bright_next = s_item.brightness_level;
        end else if (push_valid && push_ready) begin
            busy_next = 1'b0;
        end else if (step_en) begin
            step_next = step_reg + 1'b1;
            num_next  = {3'b000, quot};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        step_reg   <= step_next;
        num_reg    <= num_next;
        dec_reg    <= dec_next;
        colon_reg  <= colon_next;
        shift_reg  <= shift_next;
        bright_reg <= bright_next;
        if (step_en && !accept) begin
            dig_reg[step_reg] <= sfb_pkg::dig_code_t'(rem[3:0]);
        end
    end

endmodule

### rtl/sfb_queue.sv
// Two-entry queue between the front end and the frame sequencer.
// Generic on payload width; depends on nothing else.
module sfb_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] store_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/sfb_back.sv
// Back end: walks one queued frame byte by byte into a registered output stage.
// Uses sfb_pkg for the phase enum, configuration struct and lookup tables.
module sfb_back #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  sfb_pkg::cfg_t                        cfg,
    input  logic                                 pop_valid,
    output logic                                 pop_ready,
    input  sfb_pkg::dig_code_t [DIGIT_COUNT-1:0] pop_digits,
    input  sfb_pkg::entry_ctl_t                  pop_ctl,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output sfb_pkg::out_item_t                   m_item
);

    localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int SRC_W = $clog2(DIGIT_COUNT + 8);
    localparam logic [IDX_W-1:0] LAST_DIGIT = IDX_W'(DIGIT_COUNT - 1);

    sfb_pkg::phase_t                      phase_reg,  phase_next;
    logic [IDX_W-1:0]                     digit_reg,  digit_next;
    logic                                 active_reg, active_next;
    sfb_pkg::dig_code_t [DIGIT_COUNT-1:0] digits_reg;
    sfb_pkg::entry_ctl_t                  ctl_reg;
    logic                                 m_valid_reg, m_valid_next;
    sfb_pkg::out_item_t                   m_item_reg,  m_item_next;

    logic                                 load;
    logic                                 frame_end;
    logic [SRC_W-1:0]                     src;
    sfb_pkg::dig_code_t                   src_code;
    logic [7:0]                           digit_seg;

    assign load      = active_reg && (!m_valid_reg || m_ready);
    assign frame_end = load && (phase_reg == sfb_pkg::PH_BRIGHT);
    assign pop_ready = !active_reg || frame_end;

    // The shift selects a digit further right; slots past the end are vacant.
    assign src      = SRC_W'(digit_reg) + SRC_W'(ctl_reg.shift);
    assign src_code = digits_reg[src[IDX_W-1:0]];

    always_comb begin
        if (src >= SRC_W'(DIGIT_COUNT)) begin
            digit_seg = sfb_pkg::VACANT_SEG;
        end else begin
            if (src_code >= sfb_pkg::DIG_BLANK) begin
                digit_seg = cfg.blank_code;
            end else begin
                digit_seg = sfb_pkg::seg_lookup(src_code);
            end
            if (ctl_reg.colon_or) begin
                digit_seg = digit_seg | sfb_pkg::COLON_SEG;
            end
        end
    end

    always_comb begin
        phase_next   = phase_reg;
        digit_next   = digit_reg;
        active_next  = active_reg;
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (load) begin
            m_valid_next = 1'b1;
            case (phase_reg)
                sfb_pkg::PH_CMD: begin
                    m_item_next = '{frame_byte: cfg.first_cmd, stop_after: 1'b1,
                                    last_of_frame: 1'b0};
                    phase_next  = sfb_pkg::PH_ADDR;
                end
                sfb_pkg::PH_ADDR: begin
                    m_item_next = '{frame_byte: cfg.addr_cmd, stop_after: 1'b0,
                                    last_of_frame: 1'b0};
                    phase_next  = sfb_pkg::PH_DIGIT;
                    digit_next  = '0;
                end
                sfb_pkg::PH_DIGIT: begin
                    m_item_next = '{frame_byte: digit_seg,
                                    stop_after: (digit_reg == LAST_DIGIT),
                                    last_of_frame: 1'b0};
                    if (digit_reg == LAST_DIGIT) begin
                        phase_next = sfb_pkg::PH_BRIGHT;
                    end else begin
                        digit_next = digit_reg + 1'b1;
                    end
                end
                sfb_pkg::PH_BRIGHT: begin
                    m_item_next = '{frame_byte: sfb_pkg::bright_lookup(ctl_reg.bright),
                                    stop_after: 1'b1, last_of_frame: 1'b1};
                    active_next = 1'b0;
                end
                default: begin
                    phase_next = sfb_pkg::PH_CMD;
                end
            endcase
        end
        if (pop_valid && pop_ready) begin
            active_next = 1'b1;
            phase_next  = sfb_pkg::PH_CMD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= sfb_pkg::PH_CMD;
            active_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            active_reg  <= active_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg  <= digit_next;
        m_item_reg <= m_item_next;
        if (pop_valid && pop_ready) begin
            digits_reg <= pop_digits;
            ctl_reg    <= pop_ctl;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

### rtl/seven_segment_frame_builder.sv
// Top level of the seven-segment frame builder: configuration registers and the
// front end, queue and frame sequencer. Depends on sfb_pkg, sfb_front, sfb_queue, sfb_back.
//
// Usage:
//   Input channel (s_valid/s_ready/s_item) takes one number with display options.
//   Result channel (m_valid/m_ready/m_item) returns DIGIT_COUNT+3 bytes per input:
//   first command, address command, DIGIT_COUNT segment codes, brightness code.
//   Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once and
//   should only be issued while no frame is in flight.
// Timing:
//   After acceptance a frame passes the front end, the queue and the byte
//   sequencer into the output register; in decimal mode the front end first
//   extracts one decimal digit per cycle with a divide-by-ten unit.
//   Sustained throughput is one byte per cycle while m_ready is high and a frame
//   is queued, set by the byte sequencer that feeds the output register.
// Reset:
//   aresetn clears all handshake state and restores the register defaults.
// Stalls:
//   A low m_ready holds the output byte; the two-entry queue keeps the front
//   end accepting until it fills, after which s_ready drops.
module seven_segment_frame_builder #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sfb_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output sfb_pkg::out_item_t m_item,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    localparam int Q_WIDTH = DIGIT_COUNT * sfb_pkg::DIG_CODE_W + $bits(sfb_pkg::entry_ctl_t);

    sfb_pkg::cfg_t                        cfg_reg, cfg_next;
    logic                                 push_valid;
    logic                                 push_ready;
    sfb_pkg::dig_code_t [DIGIT_COUNT-1:0] push_digits;
    sfb_pkg::entry_ctl_t                  push_ctl;
    logic                                 pop_valid;
    logic                                 pop_ready;
    logic [Q_WIDTH-1:0]                   pop_data;
    sfb_pkg::dig_code_t [DIGIT_COUNT-1:0] pop_digits;
    sfb_pkg::entry_ctl_t                  pop_ctl;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                sfb_pkg::CFG_FIRST_CMD:  cfg_next.first_cmd  = cfg_data;
                sfb_pkg::CFG_ADDR_CMD:   cfg_next.addr_cmd   = cfg_data;
                sfb_pkg::CFG_BLANK_CODE: cfg_next.blank_code = cfg_data;
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{first_cmd: sfb_pkg::FIRST_CMD_RESET,
                         addr_cmd: sfb_pkg::ADDR_CMD_RESET,
                         blank_code: sfb_pkg::BLANK_CODE_RESET};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sfb_front #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_digits (push_digits),
        .push_ctl    (push_ctl)
    );

    sfb_queue #(
        .WIDTH (Q_WIDTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_digits, push_ctl}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign {pop_digits, pop_ctl} = pop_data;

    sfb_back #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_digits (pop_digits),
        .pop_ctl    (pop_ctl),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

### rtl/sfb_checker.sv
// Port-level checks for the seven-segment frame builder, bound to the top level.
// Depends on sfb_pkg for the payload types.
module sfb_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input sfb_pkg::out_item_t m_item
);

    // Nothing is left pending by reset, so both sides come up clean.
    a_reset_out_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_reset_in_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready right after reset");

    // The final byte of a frame always closes a bus transfer.
    a_last_has_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.last_of_frame |-> m_item.stop_after)
        else $error("last byte of frame without stop");

    // A frame is longer than one byte, so a last byte never directly follows another.
    a_no_double_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_item.last_of_frame |=> !(m_valid && m_item.last_of_frame))
        else $error("two frame ends in a row");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

endmodule

bind seven_segment_frame_builder sfb_checker u_sfb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

### verif/seven_segment_frame_builder_tb.sv
// Self-checking testbench for seven_segment_frame_builder: random bursts on the input,
// random stalls on the output and a frame predictor checked byte by byte.
// Depends on sfb_pkg and the RTL of the block only.
module seven_segment_frame_builder_tb;

    localparam int DIGITS = 4;
    localparam int FRAME_BYTES = DIGITS + 3;
    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_PER_PHASE = 36;

    // Segment glyphs for digit values 0..17 (hex glyphs, colon, dash), value 0 lowest.
    localparam logic [18*8-1:0] GLYPHS = {
        8'h02, 8'h01, 8'h8E, 8'h9E, 8'h7A, 8'h9C, 8'h3E, 8'hEE, 8'hF6,
        8'hFE, 8'hE0, 8'hBE, 8'hB6, 8'h66, 8'hF2, 8'hDA, 8'h60, 8'hFC
    };
    localparam logic [8*8-1:0] DIMMER_CODES = {
        8'hF1, 8'h71, 8'hB1, 8'h31, 8'hD1, 8'h51, 8'h91, 8'h01
    };
    localparam logic [7:0] COLON_BIT = 8'h01;
    localparam logic [7:0] EMPTY_SLOT = 8'h00;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    sfb_pkg::in_item_t  s_item = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    sfb_pkg::out_item_t m_item;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [7:0]         cfg_data = '0;

    // Testbench copy of the configuration registers.
    logic [7:0] first_cmd = sfb_pkg::FIRST_CMD_RESET;
    logic [7:0] addr_cmd = sfb_pkg::ADDR_CMD_RESET;
    logic [7:0] blank_code = sfb_pkg::BLANK_CODE_RESET;

    sfb_pkg::in_item_t  numbers_to_send[$];
    sfb_pkg::out_item_t frame_bytes[$];

    int unsigned failures = 0;
    int unsigned reports = 0;
    int unsigned idle_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          stall_mode = 0;
    int          mode_left = 0;

    seven_segment_frame_builder #(
        .DIGIT_COUNT(DIGITS)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic void expect_byte(input logic [7:0] code, input logic stop,
                                        input logic last);
        frame_bytes.push_back({code, stop, last});
    endfunction

    // Works out the whole frame that one number produces under the current registers.
    function automatic void predict_frame(input sfb_pkg::in_item_t it);
        logic [7:0]  seg [DIGITS];
        int unsigned rest;
        int unsigned weight;
        int unsigned d;
        int unsigned src;
        bit          leading;
        bit          blank;
        bit          dec_colon;
        rest = 32'(it.value);
        weight = 10 ** (DIGITS - 1);
        leading = 1'b1;
        dec_colon = it.radix_mode && it.colon_on;
        for (int p = 0; p < DIGITS; p++) begin
            if (it.radix_mode) begin
                d = rest / weight;
                rest = rest - d * weight;
                weight = weight / 10;
            end else begin
                d = ((DIGITS - 1 - p) * 4 < 16)
                    ? 32'((it.value >> ((DIGITS - 1 - p) * 4)) & 16'hF) : 0;
            end
            blank = (d == 0) && leading && (p != DIGITS - 1) && !dec_colon;
            if (!blank) begin
                leading = 1'b0;
            end
            seg[p] = (blank || d >= 18) ? blank_code : GLYPHS[d*8 +: 8];
            if (dec_colon) begin
                seg[p] = seg[p] | COLON_BIT;
            end
        end
        expect_byte(first_cmd, 1'b1, 1'b0);
        expect_byte(addr_cmd, 1'b0, 1'b0);
        for (int p = 0; p < DIGITS; p++) begin
            src = p + it.shift_positions;
            expect_byte((src < DIGITS) ? seg[src] : EMPTY_SLOT, p == DIGITS - 1, 1'b0);
        end
        expect_byte(DIMMER_CODES[it.brightness_level*8 +: 8], 1'b1, 1'b1);
    endfunction

    function automatic void queue_number(input logic [15:0] v, input logic dec,
                                         input logic [2:0] sh, input logic [2:0] br,
                                         input logic col);
        sfb_pkg::in_item_t it;
        it.value = v;
        it.radix_mode = dec;
        it.shift_positions = sh;
        it.brightness_level = br;
        it.colon_on = col;
        numbers_to_send.push_back(it);
    endfunction

    function automatic void queue_random_numbers(input int count);
        logic [15:0] v;
        logic [2:0]  sh;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(0, 4))
                0:       v = 16'($urandom_range(0, 15));
                1:       v = 16'($urandom_range(0, 999));
                2:       v = 16'($urandom_range(9990, 19999));
                default: v = 16'($urandom_range(0, 65535));
            endcase
            sh = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4));
            queue_number(v, 1'($urandom_range(0, 1)), sh, 3'($urandom_range(0, 7)),
                         1'($urandom_range(0, 1)));
        end
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            sfb_pkg::CFG_FIRST_CMD:  first_cmd = data;
            sfb_pkg::CFG_ADDR_CMD:   addr_cmd = data;
            sfb_pkg::CFG_BLANK_CODE: blank_code = data;
            default: ;
        endcase
    endtask

    // Holds the sender back until every frame in flight has been fully received.
    task automatic wait_drained();
        while (numbers_to_send.size() != 0 || s_valid || frame_bytes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (FRAME_BYTES + 2) @(posedge aclk);
    endtask

    // Sender: bursts of random length separated by random gaps, sometimes none.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_frame(s_item);
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_valid <= 1'b0;
                end else if (numbers_to_send.size() != 0) begin
                    s_item <= numbers_to_send.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left = burst_left - 1;
                    end else begin
                        burst_left = $urandom_range(1, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: switches between always ready, coin-flip stalls and heavy stalls.
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(10, 60);
        end else begin
            mode_left = mode_left - 1;
        end
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (frame_bytes.size() == 0) begin
                failures = failures + 1;
                if (reports < MAX_REPORTS) begin
                    reports = reports + 1;
                    $display("Unexpected transaction: byte %02h stop %0b last %0b",
                             m_item.frame_byte, m_item.stop_after, m_item.last_of_frame);
                end
            end else begin
                sfb_pkg::out_item_t want;
                want = frame_bytes.pop_front();
                if (m_item.frame_byte !== want.frame_byte
                        || m_item.stop_after !== want.stop_after
                        || m_item.last_of_frame !== want.last_of_frame) begin
                    failures = failures + 1;
                    if (reports < MAX_REPORTS) begin
                        reports = reports + 1;
                        $display("Mismatch: expected byte %02h stop %0b last %0b, got %02h %0b %0b",
                                 want.frame_byte, want.stop_after, want.last_of_frame,
                                 m_item.frame_byte, m_item.stop_after, m_item.last_of_frame);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Register defaults: extremes, blanking, table edges and shifts.
        queue_number(16'h0000, 1'b0, 3'd0, 3'd0, 1'b0);
        queue_number(16'hFFFF, 1'b0, 3'd0, 3'd1, 1'b1);
        queue_number(16'h000A, 1'b0, 3'd0, 3'd2, 1'b0);
        queue_number(16'h0100, 1'b0, 3'd1, 3'd3, 1'b0);
        queue_number(16'h1234, 1'b0, 3'd2, 3'd4, 1'b0);
        queue_number(16'hABCD, 1'b0, 3'd3, 3'd5, 1'b1);
        queue_number(16'h5E6F, 1'b0, 3'd4, 3'd6, 1'b0);
        queue_number(16'h789A, 1'b0, 3'd7, 3'd7, 1'b0);
        queue_number(16'd0, 1'b1, 3'd0, 3'd0, 1'b0);
        queue_number(16'd7, 1'b1, 3'd0, 3'd1, 1'b0);
        queue_number(16'd9999, 1'b1, 3'd0, 3'd2, 1'b0);
        queue_number(16'd65535, 1'b1, 3'd0, 3'd3, 1'b0);
        queue_number(16'd10000, 1'b1, 3'd0, 3'd4, 1'b0);
        queue_number(16'd16000, 1'b1, 3'd0, 3'd5, 1'b0);
        queue_number(16'd17999, 1'b1, 3'd0, 3'd6, 1'b0);
        queue_number(16'd18000, 1'b1, 3'd0, 3'd7, 1'b0);
        queue_number(16'd0, 1'b1, 3'd0, 3'd0, 1'b1);
        queue_number(16'd42, 1'b1, 3'd0, 3'd1, 1'b1);
        queue_number(16'd65535, 1'b1, 3'd1, 3'd2, 1'b1);
        queue_number(16'd1005, 1'b1, 3'd2, 3'd3, 1'b1);
        queue_number(16'd305, 1'b1, 3'd3, 3'd4, 1'b0);
        queue_number(16'd8080, 1'b1, 3'd5, 3'd5, 1'b1);
        queue_number(16'd12, 1'b1, 3'd6, 3'd6, 1'b0);
        wait_drained();

        write_reg(sfb_pkg::CFG_FIRST_CMD, 8'hFF);
        write_reg(sfb_pkg::CFG_ADDR_CMD, 8'hFF);
        write_reg(sfb_pkg::CFG_BLANK_CODE, 8'hFF);
        queue_random_numbers(RANDOM_PER_PHASE);
        wait_drained();

        write_reg(sfb_pkg::CFG_FIRST_CMD, 8'h00);
        write_reg(sfb_pkg::CFG_ADDR_CMD, 8'h00);
        write_reg(sfb_pkg::CFG_BLANK_CODE, 8'h00);
        queue_random_numbers(RANDOM_PER_PHASE);
        wait_drained();

        write_reg(sfb_pkg::CFG_FIRST_CMD, 8'($urandom_range(0, 255)));
        write_reg(sfb_pkg::CFG_ADDR_CMD, 8'($urandom_range(0, 255)));
        write_reg(sfb_pkg::CFG_BLANK_CODE, 8'($urandom_range(1, 254)));
        queue_random_numbers(RANDOM_PER_PHASE);
        wait_drained();

        if (frame_bytes.size() != 0) begin
            failures = failures + 1;
            $display("%0d expected bytes never arrived", frame_bytes.size());
        end
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### sim.f
rtl/sfb_pkg.sv
rtl/sfb_front.sv
rtl/sfb_queue.sv
rtl/sfb_back.sv
rtl/seven_segment_frame_builder.sv
rtl/sfb_checker.sv
verif/seven_segment_frame_builder_tb.sv
